### hw/rtl/rpfa_pkg.sv
package rpfa_pkg;

  localparam int unsigned ADDR_W         = 40;
  localparam int unsigned OP_W           = 3;
  localparam int unsigned RUN_W          = 12;
  localparam int unsigned STATUS_W       = 3;
  localparam int unsigned COUNT_W        = 8;
  localparam int unsigned CFG_IDX_W      = 2;

  localparam int unsigned FRAMES_DEF     = 2048;
  localparam int unsigned PAGE_SHIFT_DEF = 12;

  localparam logic [COUNT_W-1:0] RESERVED_COUNT = COUNT_W'(100);
  localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;

  localparam logic [ADDR_W-1:0] BASE_RST  = 40'h00_8000_0000;
  localparam logic [ADDR_W-1:0] START_RST = 40'h00_8000_0000;
  localparam logic [ADDR_W-1:0] END_RST   = 40'h00_8080_0000;

  typedef enum logic [OP_W-1:0] {
    OP_INIT      = 3'd0,
    OP_ALLOC     = 3'd1,
    OP_ALLOC_RUN = 3'd2,
    OP_FREE      = 3'd3,
    OP_SHARE     = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_NO_SPACE     = 3'd1,
    ST_NONEXIST     = 3'd2,
    ST_ALREADY_FREE = 3'd3,
    ST_IGNORED      = 3'd4,
    ST_SATURATED    = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_ADDR       = 2'd0,
    CFG_FREE_START_ADDR = 2'd1,
    CFG_MEMORY_END_ADDR = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_INIT,
    S_SCAN,
    S_MARK,
    S_LOOKUP,
    S_UPDATE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] address;
    logic [RUN_W-1:0]  run_length;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   result_addr;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base_addr;
    logic [ADDR_W-1:0] free_start_addr;
    logic [ADDR_W-1:0] memory_end_addr;
  } cfg_t;

  // Address decode results handed from the map unit to the sequencer
  typedef struct packed {
    status_e           loc_status;
    logic [ADDR_W-1:0] frame;
    logic              init_ok;
    logic [ADDR_W-1:0] init_start;
    logic [ADDR_W-1:0] init_count;
  } map_t;

endpackage

### hw/rtl/rpfa_addr_map.sv
module rpfa_addr_map #(
  parameter int unsigned FRAMES          = rpfa_pkg::FRAMES_DEF,
  parameter int unsigned PAGE_SHIFT_BITS = rpfa_pkg::PAGE_SHIFT_DEF
) (
  input  rpfa_pkg::cfg_t                    cfg_i,
  input  logic [rpfa_pkg::ADDR_W-1:0]       address_i,
  output rpfa_pkg::map_t                    map_o
);
  import rpfa_pkg::*;

  localparam logic [ADDR_W-1:0] FRAMES_A = ADDR_W'(FRAMES);

  logic [ADDR_W-1:0] offset;
  logic [ADDR_W-1:0] frame;

  assign offset = address_i - cfg_i.base_addr;
  assign frame  = offset >> PAGE_SHIFT_BITS;

  // Map a physical address to a frame index and a status
  always_comb begin
    map_o.frame = frame;
    if (address_i < cfg_i.base_addr) begin
      map_o.loc_status = ST_IGNORED;
    end else if (address_i >= cfg_i.memory_end_addr) begin
      map_o.loc_status = ST_NONEXIST;
    end else if (frame >= FRAMES_A) begin
      map_o.loc_status = ST_NONEXIST;
    end else begin
      map_o.loc_status = ST_OK;
    end
  end

  // Free window for init: start frame and frame count
  assign map_o.init_ok = (cfg_i.free_start_addr >= cfg_i.base_addr) &&
                         (cfg_i.memory_end_addr > cfg_i.free_start_addr);
  assign map_o.init_start = (cfg_i.free_start_addr - cfg_i.base_addr) >> PAGE_SHIFT_BITS;
  assign map_o.init_count = (cfg_i.memory_end_addr - cfg_i.free_start_addr) >> PAGE_SHIFT_BITS;

endmodule

### hw/rtl/refcounted_page_frame_allocator.sv
// Page frame allocator with an 8-bit reference count per frame.
// Input channel (in_valid_i/in_ready_o, in_data_i) takes one command per
// transfer: init, alloc, alloc_run, free or share. Output channel
// (out_valid_o/out_ready_i, out_data_o) returns exactly one result per command.
// Configuration: a write with cfg_we_i high updates the register selected by
// cfg_index_i (0 base, 1 free start, 2 memory end); write only while idle.
// The counts live in one FRAMES-deep synchronous RAM with one write port and
// one registered read port; every command that uses the counts goes through it.
// Steps per command, from transfer in to result ready:
//   free, share       : read, modify, write back
//   init              : one RAM write per frame
//   alloc             : downward scan, one frame per cycle
//   alloc_run of N    : scan, then N marking writes
//   bad args/unknown  : straight to the result
// After reset a clearing pass writes zero to every frame, with in_ready_o
// low; configuration writes are taken meanwhile.
// One command is handled at a time. A finished result sits in an output
// register; while the receiver stalls the next command is still taken and
// processed, and its result waits until the output register frees up.
module refcounted_page_frame_allocator #(
  parameter int unsigned FRAMES          = rpfa_pkg::FRAMES_DEF,
  parameter int unsigned PAGE_SHIFT_BITS = rpfa_pkg::PAGE_SHIFT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rpfa_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [rpfa_pkg::ADDR_W-1:0]       cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  rpfa_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output rpfa_pkg::out_item_t               out_data_o
);
  import rpfa_pkg::*;

  localparam int unsigned IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam logic [IW-1:0] LAST_FRAME = IW'(FRAMES - 1);
  localparam logic [31:0]   FRAMES_32  = 32'(FRAMES);

  // Configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.base_addr       <= BASE_RST;
      cfg_q.free_start_addr <= START_RST;
      cfg_q.memory_end_addr <= END_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BASE_ADDR:       cfg_q.base_addr       <= cfg_wdata_i;
        CFG_FREE_START_ADDR: cfg_q.free_start_addr <= cfg_wdata_i;
        CFG_MEMORY_END_ADDR: cfg_q.memory_end_addr <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Address decode
  map_t map;

  rpfa_addr_map #(
    .FRAMES          (FRAMES),
    .PAGE_SHIFT_BITS (PAGE_SHIFT_BITS)
  ) u_addr_map (
    .cfg_i     (cfg_q),
    .address_i (in_data_i.address),
    .map_o     (map)
  );

  // Count RAM: one write and one read per cycle, registered read data
  logic [COUNT_W-1:0] count_mem [FRAMES];
  logic               mem_we;
  logic [IW-1:0]      mem_waddr;
  logic [COUNT_W-1:0] mem_wdata;
  logic               mem_re;
  logic [IW-1:0]      mem_raddr;
  logic [COUNT_W-1:0] mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      count_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= count_mem[mem_raddr];
    end
  end

  // Sequencer state
  state_e             state_q, state_d;
  logic [IW-1:0]      ptr_q, ptr_d;
  logic               rd_vld_q, rd_vld_d;
  logic               out_valid_q, out_valid_d;
  logic [IW-1:0]      rd_idx_q, rd_idx_d;
  logic [RUN_W-1:0]   cnt_q, cnt_d;
  logic [RUN_W-1:0]   need_q, need_d;
  logic [RUN_W-1:0]   left_q, left_d;
  logic [IW-1:0]      lo_q, lo_d;
  logic [OP_W-1:0]    op_q, op_d;
  logic [ADDR_W-1:0]  init_s_q, init_s_d;
  logic [ADDR_W-1:0]  init_n_q, init_n_d;
  logic               init_ok_q, init_ok_d;
  logic [ADDR_W-1:0]  res_addr_q, res_addr_d;
  status_e            res_st_q, res_st_d;
  out_item_t          out_data_q, out_data_d;

  logic               in_xfer;
  logic               run_bad;
  logic [RUN_W-1:0]   cnt_inc;
  logic               scan_hit;
  logic               scan_fail;
  logic               ptr_last;
  logic               out_free;
  logic [ADDR_W-1:0]  ptr_a;
  logic               in_window;
  logic [ADDR_W-1:0]  run_addr;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign run_bad    = (in_data_i.run_length == '0) ||
                      (32'(in_data_i.run_length) >= FRAMES_32);
  assign cnt_inc    = cnt_q + RUN_W'(1);
  assign scan_hit   = rd_vld_q && (mem_rdata_q == '0) && (cnt_inc == need_q);
  assign scan_fail  = !rd_vld_q && (ptr_q == '0);
  assign ptr_last   = (ptr_q == LAST_FRAME);
  assign out_free   = !out_valid_q || out_ready_i;
  assign ptr_a      = ADDR_W'(ptr_q);
  assign in_window  = init_ok_q && (ptr_a >= init_s_q) && ((ptr_a - init_s_q) < init_n_q);
  assign run_addr   = cfg_q.base_addr + (ADDR_W'(lo_q) << PAGE_SHIFT_BITS);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (ptr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_xfer) begin
          unique case (in_data_i.operation) inside
            OP_INIT:      state_d = S_INIT;
            OP_ALLOC:     state_d = S_SCAN;
            OP_ALLOC_RUN: state_d = run_bad ? S_DONE : S_SCAN;
            OP_FREE, OP_SHARE: begin
              state_d = (map.loc_status == ST_OK) ? S_LOOKUP : S_DONE;
            end
            default:      state_d = S_DONE;
          endcase
        end
      end
      S_INIT: begin
        if (ptr_last) state_d = S_DONE;
      end
      S_SCAN: begin
        if (scan_hit) begin
          state_d = S_MARK;
        end else if (scan_fail) begin
          state_d = S_DONE;
        end
      end
      S_MARK: begin
        if (left_q == RUN_W'(1)) state_d = S_DONE;
      end
      S_LOOKUP: state_d = S_UPDATE;
      S_UPDATE: state_d = S_DONE;
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = ptr_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = ptr_q;
    ptr_d       = ptr_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    cnt_d       = cnt_q;
    need_d      = need_q;
    left_d      = left_q;
    lo_d        = lo_q;
    op_d        = op_q;
    init_s_d    = init_s_q;
    init_n_d    = init_n_q;
    init_ok_d   = init_ok_q;
    res_addr_d  = res_addr_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        ptr_d     = ptr_q + IW'(1);
      end
      S_IDLE: begin
        if (in_xfer) begin
          res_addr_d = '0;
          res_st_d   = ST_OK;
          op_d       = in_data_i.operation;
          cnt_d      = '0;
          ptr_d      = LAST_FRAME;
          unique case (in_data_i.operation) inside
            OP_INIT: begin
              ptr_d     = '0;
              init_s_d  = map.init_start;
              init_n_d  = map.init_count;
              init_ok_d = map.init_ok;
            end
            OP_ALLOC: need_d = RUN_W'(1);
            OP_ALLOC_RUN: begin
              need_d = in_data_i.run_length;
              if (run_bad) res_st_d = ST_NO_SPACE;
            end
            OP_FREE, OP_SHARE: begin
              rd_idx_d = map.frame[IW-1:0];
              res_st_d = map.loc_status;
            end
            default: res_st_d = ST_IGNORED;
          endcase
        end
      end
      S_INIT: begin
        // Reserve every frame, except those inside the free window
        mem_we    = 1'b1;
        mem_wdata = in_window ? '0 : RESERVED_COUNT;
        ptr_d     = ptr_q + IW'(1);
      end
      S_SCAN: begin
        // Issue reads downward to frame 1; count zero frames in a row
        if (ptr_q != '0) begin
          mem_re   = 1'b1;
          rd_vld_d = 1'b1;
          rd_idx_d = ptr_q;
          ptr_d    = ptr_q - IW'(1);
        end
        if (rd_vld_q) begin
          cnt_d = (mem_rdata_q == '0) ? cnt_inc : '0;
        end
        if (scan_hit) begin
          lo_d     = rd_idx_q;
          ptr_d    = rd_idx_q;
          left_d   = need_q;
          rd_vld_d = 1'b0;
        end else if (scan_fail) begin
          res_st_d = ST_NO_SPACE;
        end
      end
      S_MARK: begin
        mem_we    = 1'b1;
        mem_wdata = COUNT_W'(1);
        ptr_d     = ptr_q + IW'(1);
        left_d    = left_q - RUN_W'(1);
        if (left_q == RUN_W'(1)) res_addr_d = run_addr;
      end
      S_LOOKUP: begin
        mem_re    = 1'b1;
        mem_raddr = rd_idx_q;
      end
      S_UPDATE: begin
        mem_waddr = rd_idx_q;
        if (op_q == OP_FREE) begin
          if (mem_rdata_q != '0) begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata_q - COUNT_W'(1);
          end else begin
            res_st_d = ST_ALREADY_FREE;
          end
        end else begin
          if (mem_rdata_q != COUNT_MAX) begin
            mem_we    = 1'b1;
            mem_wdata = mem_rdata_q + COUNT_W'(1);
          end else begin
            res_st_d = ST_SATURATED;
          end
        end
      end
      S_DONE: begin
        // Hold the result until the output register frees up
        if (out_free) begin
          out_valid_d            = 1'b1;
          out_data_d.result_addr = res_addr_q;
          out_data_d.status      = res_st_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ptr_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    cnt_q      <= cnt_d;
    need_q     <= need_d;
    left_q     <= left_d;
    lo_q       <= lo_d;
    op_q       <= op_d;
    init_s_q   <= init_s_d;
    init_n_q   <= init_n_d;
    init_ok_q  <= init_ok_d;
    res_addr_q <= res_addr_d;
    res_st_q   <= res_st_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Frame zero is never examined by the allocation scan
  a_scan_skips_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && rd_vld_q) |-> (rd_idx_q != '0))
    else $error("allocation scan examined frame zero");

  // Marking writes a count of one and never touches frame zero
  a_mark_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MARK) |-> (mem_we && mem_wdata == COUNT_W'(1) && mem_waddr != '0))
    else $error("run marking wrote a bad count or frame zero");

  // Free and share move a count by exactly one
  a_update_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPDATE && mem_we) |->
      ((mem_wdata == mem_rdata_q + COUNT_W'(1)) || (mem_wdata == mem_rdata_q - COUNT_W'(1))))
    else $error("count update changed a count by more than one");

  // The scan only reads; no count changes while it runs
  a_scan_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> !mem_we)
    else $error("count RAM written during allocation scan");

endmodule

### tb/refcounted_page_frame_allocator_tb.sv
module refcounted_page_frame_allocator_tb;
  import rpfa_pkg::*;

  typedef logic [ADDR_W-1:0] paddr_t;

  // Operation codes the block does not define; each must come back ignored
  localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

  localparam paddr_t ADDR_TOP = '1;

  // Tracks the count of every frame and the address map, predicts the result of
  // each accepted command and checks the results in order.
  class frame_count_ledger;
    logic [COUNT_W-1:0] refs [FRAMES_DEF];
    paddr_t             base_q;
    paddr_t             start_q;
    paddr_t             end_q;
    out_item_t          awaited[$];
    int                 mismatches;
    int                 results_seen;

    function new();
      foreach (refs[f]) refs[f] = '0;
      base_q       = BASE_RST;
      start_q      = START_RST;
      end_q        = END_RST;
      mismatches   = 0;
      results_seen = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, paddr_t v);
      case (idx)
        CFG_BASE_ADDR:       base_q  = v;
        CFG_FREE_START_ADDR: start_q = v;
        CFG_MEMORY_END_ADDR: end_q   = v;
        default: ;
      endcase
    endfunction

    function paddr_t frame_addr(int f);
      return base_q + (paddr_t'(f) << PAGE_SHIFT_DEF);
    endfunction

    function status_e locate(paddr_t a, output int unsigned idx);
      paddr_t off;
      idx = 0;
      if (a < base_q) return ST_IGNORED;
      if (a >= end_q) return ST_NONEXIST;
      off = (a - base_q) >> PAGE_SHIFT_DEF;
      if (off >= paddr_t'(FRAMES_DEF)) return ST_NONEXIST;
      idx = int'(off);
      return ST_OK;
    endfunction

    function void clear_table();
      paddr_t s;
      paddr_t n;
      foreach (refs[f]) refs[f] = RESERVED_COUNT;
      if (start_q < base_q || end_q <= start_q) return;
      s = (start_q - base_q) >> PAGE_SHIFT_DEF;
      n = (end_q - start_q) >> PAGE_SHIFT_DEF;
      for (int f = 0; f < FRAMES_DEF; f++)
        if (paddr_t'(f) >= s && (paddr_t'(f) - s) < n) refs[f] = '0;
    endfunction

    function status_e grab_frame(output paddr_t a);
      a = '0;
      for (int i = FRAMES_DEF - 1; i >= 1; i--) begin
        if (refs[i] == 0) begin
          refs[i] = 1;
          a = frame_addr(i);
          return ST_OK;
        end
      end
      return ST_NO_SPACE;
    endfunction

    // Highest run that fits wholly above frame 0; a busy frame moves the
    // window top to just below it.
    function status_e grab_run(int n, output paddr_t a);
      int top;
      bit busy;
      a   = '0;
      top = FRAMES_DEF - 1;
      if (n == 0) return ST_NO_SPACE;
      while (top >= n) begin
        busy = 1'b0;
        for (int j = top; j > top - n; j--) begin
          if (refs[j] != 0) begin
            busy = 1'b1;
            top  = j - 1;
            break;
          end
        end
        if (!busy) begin
          for (int j = top - n + 1; j <= top; j++) refs[j] = 1;
          a = frame_addr(top - n + 1);
          return ST_OK;
        end
      end
      return ST_NO_SPACE;
    endfunction

    function out_item_t take_cmd(in_item_t c);
      out_item_t   r;
      status_e     st;
      paddr_t      got_addr;
      int unsigned idx;
      r        = '0;
      got_addr = '0;
      st       = ST_OK;
      case (c.operation)
        OP_INIT:      clear_table();
        OP_ALLOC:     st = grab_frame(got_addr);
        OP_ALLOC_RUN: st = grab_run(int'(c.run_length), got_addr);
        OP_FREE: begin
          st = locate(c.address, idx);
          if (st == ST_OK) begin
            if (refs[idx] != 0) refs[idx]--;
            else st = ST_ALREADY_FREE;
          end
        end
        OP_SHARE: begin
          st = locate(c.address, idx);
          if (st == ST_OK) begin
            if (refs[idx] != COUNT_MAX) refs[idx]++;
            else st = ST_SATURATED;
          end
        end
        default: st = ST_IGNORED;
      endcase
      r.result_addr = got_addr;
      r.status      = st;
      awaited.push_back(r);
      return r;
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction

    task report(string msg);
      $display("MISMATCH result %0d: %s", results_seen, msg);
      mismatches++;
    endtask

    task match_result(out_item_t got);
      out_item_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected result addr %h status %0d",
                         got.result_addr, got.status));
        return;
      end
      want = awaited.pop_front();
      if (got.result_addr !== want.result_addr)
        report($sformatf("result_addr %h, want %h", got.result_addr, want.result_addr));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
    endtask
  endclass

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  paddr_t    cfg_wdata_i = '0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  frame_count_ledger ledger;
  paddr_t            handed_out[$];   // addresses from recent allocations
  int                send_idle;       // percent of cycles the sender holds off
  int                recv_idle;       // percent of cycles the receiver stalls

  refcounted_page_frame_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stall the result channel at random; the rate follows the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle);
  end

  // Check every result transfer against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) ledger.match_result(out_data_o);
  end

  function automatic paddr_t page(paddr_t b, int f);
    return b + (paddr_t'(f) << PAGE_SHIFT_DEF);
  endfunction

  function automatic paddr_t rand_addr();
    return paddr_t'({$urandom, $urandom});
  endfunction

  task automatic put_reg(cfg_idx_e idx, paddr_t v);
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    ledger.set_reg(idx, v);
  endtask

  // Rewrite the whole address map on back-to-back cycles; call only when idle.
  task automatic program_map(paddr_t b, paddr_t s, paddr_t e);
    cfg_we_i <= 1'b1;
    put_reg(CFG_BASE_ADDR, b);
    put_reg(CFG_FREE_START_ADDR, s);
    put_reg(CFG_MEMORY_END_ADDR, e);
    cfg_we_i <= 1'b0;
  endtask

  // Present one command, hold it until the transfer, then record the
  // prediction. Valid stays high when the next command follows with no gap.
  task automatic issue(in_item_t c, output out_item_t exp);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= c;
    // Ready only moves at rising edges, so look at it mid-cycle.
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    exp = ledger.take_cmd(c);
  endtask

  task automatic send(logic [OP_W-1:0] op, paddr_t a, logic [RUN_W-1:0] n);
    in_item_t  c;
    out_item_t exp;
    c.operation  = op;
    c.address    = a;
    c.run_length = n;
    issue(c, exp);
  endtask

  // Drop valid and let every outstanding result come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Pick a free or share target: mostly pages handed out before, some
  // anywhere in the map, a few fully random or on the map edges.
  function automatic paddr_t pick_target();
    int r;
    r = $urandom_range(9);
    if (r < 6 && handed_out.size() != 0)
      return handed_out[$urandom_range(handed_out.size() - 1)] + paddr_t'($urandom_range(4095));
    if (r < 8)
      return page(ledger.base_q, $urandom_range(FRAMES_DEF - 1)) + paddr_t'($urandom_range(4095));
    if (r == 8) return rand_addr();
    case ($urandom_range(4))
      0:       return '0;
      1:       return ledger.base_q - 1;
      2:       return ledger.end_q;
      3:       return ledger.end_q - 1;
      default: return ADDR_TOP;
    endcase
  endfunction

  function automatic in_item_t random_cmd();
    in_item_t c;
    int       p;
    int       q;
    // Fill unused fields at random too, so every input bit toggles.
    c.address    = rand_addr();
    c.run_length = RUN_W'($urandom);
    p = $urandom_range(99);
    if (p < 4) c.operation = OP_INIT;
    else if (p < 7) c.operation = OP_W'($urandom_range(OP_RSVD_5, OP_RSVD_7));
    else if (p < 35) c.operation = OP_ALLOC;
    else if (p < 50) begin
      c.operation = OP_ALLOC_RUN;
      q = $urandom_range(9);
      if (q < 6) c.run_length = RUN_W'($urandom_range(1, 4));
      else if (q < 8) c.run_length = RUN_W'($urandom_range(5, 40));
      else if (q == 8) begin
        if ($urandom_range(1) == 0) c.run_length = '0;
        else c.run_length = RUN_W'($urandom_range(FRAMES_DEF - 8, 4095));
      end
    end else begin
      c.operation = (p < 80) ? OP_FREE : OP_SHARE;
      c.address   = pick_target();
    end
    return c;
  endfunction

  task automatic random_phase(int items);
    in_item_t  c;
    out_item_t exp;
    for (int i = 0; i < items; i++) begin
      c = random_cmd();
      issue(c, exp);
      // Remember granted pages so later frees and shares hit live frames.
      if ((c.operation == OP_ALLOC || c.operation == OP_ALLOC_RUN) && exp.status == ST_OK) begin
        handed_out.push_back(exp.result_addr);
        if (handed_out.size() > 64) void'(handed_out.pop_front());
      end
    end
  endtask

  initial begin
    paddr_t b;
    ledger    = new();
    send_idle = 11;
    recv_idle = 54;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset map: all 2048 frames in the free range.
    b = BASE_RST;
    send(OP_FREE, page(b, 5), '0);          // free before any init: already free
    send(OP_INIT, '0, '0);
    send(OP_ALLOC, '0, '0);                 // top frame
    send(OP_ALLOC_RUN, '0, '0);             // zero length
    send(OP_ALLOC_RUN, ADDR_TOP, '1);       // far too long
    send(OP_ALLOC_RUN, '0, RUN_W'(FRAMES_DEF));
    send(OP_ALLOC_RUN, '0, RUN_W'(FRAMES_DEF - 1));  // top frame busy, no fit
    send(OP_ALLOC_RUN, '0, RUN_W'(FRAMES_DEF - 2));  // frames 1 up to 2046
    send(OP_ALLOC, '0, '0);                 // exhausted
    send(OP_FREE, '0, '0);                  // below base
    send(OP_SHARE, b - 1, '0);              // below base
    send(OP_FREE, END_RST, '0);             // at the end
    send(OP_SHARE, ADDR_TOP, '0);           // far beyond the end
    send(OP_FREE, b, '0);                   // frame 0 never handed out
    send(OP_SHARE, b, '0);
    send(OP_FREE, b, '0);
    send(OP_FREE, page(b, FRAMES_DEF - 1) + 40'hFFF, '0);
    send(OP_ALLOC, '0, '0);
    send(OP_RSVD_5, ADDR_TOP, '1);
    send(OP_RSVD_6, '0, '0);
    send(OP_RSVD_7, ADDR_TOP, '1);
    random_phase(30);
    drain();

    // Narrow free range; frames outside it stay reserved.
    send_idle = 54;
    recv_idle = 11;
    program_map(b, page(b, 2000), page(b, 2040));
    send(OP_INIT, '0, '0);
    send(OP_FREE, page(b, 2045), '0);       // reserved count drops to 99
    send(OP_ALLOC, '0, '0);
    send(OP_ALLOC_RUN, '0, RUN_W'(40));
    send(OP_ALLOC_RUN, '0, RUN_W'(39));
    send(OP_ALLOC, '0, '0);
    // Share a reserved frame past the top of its count, then step back down.
    for (int i = 0; i < 156; i++) send(OP_SHARE, page(b, 10), '0);
    send(OP_FREE, page(b, 10), '0);
    send(OP_INIT, '0, '0);
    handed_out.delete();
    random_phase(30);
    drain();

    // Degenerate and extreme maps, no idling on either side.
    send_idle = 0;
    recv_idle = 0;
    program_map(40'h00_1000_0000, 40'h00_0800_0000, ADDR_TOP);  // start below base
    send(OP_INIT, '0, '0);
    send(OP_ALLOC, '0, '0);
    drain();
    program_map(40'h00_4000_0000, page(40'h00_4000_0000, 8), page(40'h00_4000_0000, 8));
    send(OP_INIT, '0, '0);                  // empty range
    send(OP_ALLOC, '0, '0);
    drain();
    program_map(40'hFF_FFFF_F000, 40'hFF_FFFF_F000, ADDR_TOP);  // less than a page
    send(OP_INIT, '0, '0);
    send(OP_FREE, 40'hFF_FFFF_F000, '0);
    send(OP_SHARE, ADDR_TOP, '0);
    send(OP_FREE, 40'hFF_FFFF_FFFE, '0);
    drain();
    program_map('0, page('0, FRAMES_DEF - 8), ADDR_TOP);  // range runs past the table
    send(OP_INIT, '0, '0);
    send(OP_ALLOC, '0, '0);
    send(OP_ALLOC_RUN, '0, RUN_W'(8));
    send(OP_ALLOC_RUN, '0, RUN_W'(7));
    drain();
    program_map('0, '0, ADDR_TOP);
    send(OP_INIT, '0, '0);
    handed_out.delete();
    random_phase(30);
    drain();

    repeat (50) @(posedge clk_i);
    if (ledger.mismatches == 0 && ledger.outstanding() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #80_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### sim.f
hw/rtl/rpfa_pkg.sv
hw/rtl/rpfa_addr_map.sv
hw/rtl/refcounted_page_frame_allocator.sv
tb/refcounted_page_frame_allocator_tb.sv
